>>> design/tpsp_pkg.sv
`default_nettype none

package tpsp_pkg;

    // Default widths of the position and tick index.
    localparam int POS_BITS_DEFAULT  = 16;
    localparam int TICK_BITS_DEFAULT = 16;

    // Fixed field widths.
    localparam int DUR_BITS      = 16;
    localparam int BLEND_BITS    = 15;
    localparam int C2_BITS       = 16;
    localparam int C1_BITS       = 24;
    localparam int C0_BITS       = 28;
    localparam int PULSE_BITS    = 12;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 28;

    // Fixed-point alignment of the pulse map terms inside a Q.32 sum.
    localparam int C0_ALIGN = 16;
    localparam int C1_ALIGN = 8;
    localparam int SUM_FRAC = 32;

    // Profile numerator and denominator never exceed 2^31.
    localparam int NUM_BITS   = 31;
    localparam int MUL_A_BITS = 32;
    localparam int DUR_MIN    = 2;

    localparam int PULSE_MIN = 544;
    localparam int PULSE_MAX = 2400;

    // Register reset values.
    localparam int DUR_RESET   = 4000;
    localparam int BLEND_RESET = 1333;
    localparam int C2_RESET    = 328;
    localparam int C1_RESET    = 489685;
    localparam int C0_RESET    = 25519063;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DURATION = 3'd0,
        CFG_BLEND    = 3'd1,
        CFG_C2       = 3'd2,
        CFG_C1       = 3'd3,
        CFG_C0       = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        REQ_START = 1'b0,
        REQ_TICK  = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        PH_RISE,
        PH_CRUISE,
        PH_FALL
    } t_phase;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DEN,
        ST_NUM,
        ST_SCALE,
        ST_DIV,
        ST_POS,
        ST_SQUARE,
        ST_C2,
        ST_C1,
        ST_SAT,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

>>> design/tpsp_shift_mul.sv
`default_nettype none

// Shift-and-add multiplier, one multiplier bit per cycle, least significant first.
// When o_done rises, the product sits in o_prod shifted left by B_BITS - i_len;
// multiplier bits at and above i_len must be zero.
module tpsp_shift_mul #(
    parameter int A_BITS = tpsp_pkg::MUL_A_BITS,
    parameter int B_BITS = 2 * tpsp_pkg::POS_BITS_DEFAULT,
    localparam int LEN_BITS = $clog2(B_BITS + 1)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [LEN_BITS-1:0]        i_len,
    input  wire logic [A_BITS-1:0]          i_a,
    input  wire logic [B_BITS-1:0]          i_b,
    output logic                            o_done,
    output logic [A_BITS+B_BITS-1:0]        o_prod
);

    logic                r_busy;
    logic                r_done;
    logic [LEN_BITS-1:0] r_cnt;
    logic [A_BITS-1:0]   r_a;
    logic [A_BITS-1:0]   r_hi;
    logic [B_BITS-1:0]   r_lo;
    logic [A_BITS:0]     n_sum;

    always_comb begin
        n_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_len;
            end else if (r_busy) begin
                r_cnt <= r_cnt - LEN_BITS'(1);
                if (r_cnt == LEN_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= n_sum[A_BITS:1];
            r_lo <= {n_sum[0], r_lo[B_BITS-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

endmodule

`default_nettype wire

>>> design/trapezoidal_profile_servo_pulse_core.sv
`default_nettype none

// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+------------------------------------------
// in       | input     | i_in_valid / o_in_ready   | i_req_type, i_target_pos
// out      | output    | o_out_valid / i_out_ready | o_pulse_us, o_profile_pos, o_last_of_move
// cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// A start item, or a tick while no move is running, is taken in the idle state and gives no result.
// A tick during a move is worked through by the shared one-bit-per-cycle multiplier and the
// one-bit-per-cycle restoring divider, which handle the profile and pulse map in turn; no
// further item is taken until its point has been handed over to the output register.
// Reset is synchronous and active low; it restores the register defaults and an idle profile.
// A finished point waits in the output register, so further items are taken while it is
// stalled; only a second finished point has to wait for the first to leave.
module trapezoidal_profile_servo_pulse_core #(
    parameter int POSITION_BITS = tpsp_pkg::POS_BITS_DEFAULT,
    parameter int TICK_BITS     = tpsp_pkg::TICK_BITS_DEFAULT
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic                               i_req_type,
    input  wire logic [POSITION_BITS-1:0]           i_target_pos,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [tpsp_pkg::PULSE_BITS-1:0]         o_pulse_us,
    output logic [POSITION_BITS-1:0]                o_profile_pos,
    output logic                                    o_last_of_move,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [tpsp_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [tpsp_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    // Local names for the widths used in casts.
    localparam int P     = POSITION_BITS;
    localparam int DW    = tpsp_pkg::DUR_BITS;
    localparam int BW    = tpsp_pkg::BLEND_BITS;
    localparam int C2W   = tpsp_pkg::C2_BITS;
    localparam int C1W   = tpsp_pkg::C1_BITS;
    localparam int C0W   = tpsp_pkg::C0_BITS;
    localparam int NB    = tpsp_pkg::NUM_BITS;
    localparam int PW    = tpsp_pkg::PULSE_BITS;
    localparam int AW    = tpsp_pkg::MUL_A_BITS;
    localparam int WB    = 2 * POSITION_BITS;
    localparam int LENW  = $clog2(WB + 1);
    localparam int CMPW  = (TICK_BITS > DW) ? TICK_BITS : DW;
    localparam int DCW   = $clog2(POSITION_BITS + 1);
    // The squared term is the widest one in the pulse sum; two bits of headroom for the adds.
    localparam int SB    = WB + tpsp_pkg::C2_BITS + 2 + (AW - tpsp_pkg::C2_BITS);
    localparam int HIW   = SB - tpsp_pkg::SUM_FRAC;

    // Control and move state.
    tpsp_pkg::t_state       r_state;
    tpsp_pkg::t_state       n_state;
    logic                   r_kick;
    logic [DW-1:0]          r_dur;
    logic [BW-1:0]          r_blend;
    logic [C2W-1:0]         r_c2;
    logic [C1W-1:0]         r_c1;
    logic [C0W-1:0]         r_c0;
    logic [P-1:0]           r_start;
    logic [P-1:0]           r_goal;
    logic [TICK_BITS-1:0]   r_tick;
    logic                   r_moving;
    logic                   r_out_valid;
    logic [DCW-1:0]         r_dcnt;

    // Datapath of the point being worked on.
    logic [DW-1:0]          r_nall;
    logic [BW-1:0]          r_b;
    logic [DW-1:0]          r_n;
    logic                   r_last;
    logic                   r_down;
    logic [P-1:0]           r_mag;
    tpsp_pkg::t_phase       r_phase;
    logic [DW-1:0]          r_rdist;
    logic [NB-1:0]          r_den;
    logic [NB-1:0]          r_num;
    logic [NB-1:0]          r_rem;
    logic [P-1:0]           r_quo;
    logic [P-1:0]           r_pos;
    logic [WB-1:0]          r_sq;
    logic [SB-1:0]          r_acc;
    logic [PW-1:0]          r_pulse;
    logic [PW-1:0]          r_out_pulse;
    logic [P-1:0]           r_out_pos;
    logic                   r_out_last;

    // Combinational helpers.
    logic                   w_in_acc;
    logic                   w_fin_load;
    logic [DW-1:0]          w_nall;
    logic [BW-1:0]          w_half;
    logic [BW-1:0]          w_b_clamped;
    logic [BW-1:0]          w_b;
    logic [CMPW-1:0]        w_tick_ext;
    logic                   w_last;
    logic [DW-1:0]          w_n;
    logic [DW-1:0]          w_rest;
    logic                   w_mul_start;
    logic [LENW-1:0]        w_mul_len;
    logic [AW-1:0]          w_mul_a;
    logic [WB-1:0]          w_mul_b;
    logic                   w_mul_done;
    logic [AW+WB-1:0]       w_prod;
    logic [NB-1:0]          w_prod_short;
    logic [NB:0]            n_trial;
    logic                   w_fits;
    logic [NB-1:0]          n_rem;
    logic [HIW-1:0]         w_hi;

    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;

    // Shared multiplier for every product of the profile and the pulse map.
    tpsp_shift_mul #(
        .A_BITS (AW),
        .B_BITS (WB)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_len   (w_mul_len),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // Move geometry: the duration is at least two ticks, and the blend lies between one
    // tick and half the duration. A tick index that has reached the end gives the final point.
    always_comb begin
        w_nall      = (r_dur < DW'(tpsp_pkg::DUR_MIN)) ? DW'(tpsp_pkg::DUR_MIN) : r_dur;
        w_half      = w_nall[DW-1:1];
        w_b_clamped = (r_blend > w_half) ? w_half : r_blend;
        w_b         = (w_b_clamped == '0) ? BW'(1) : w_b_clamped;
        w_tick_ext  = CMPW'(r_tick);
        w_last      = w_tick_ext >= CMPW'(w_nall);
        w_n         = w_last ? w_nall : w_tick_ext[DW-1:0];
        w_rest      = r_nall - DW'(r_b);
    end

    // Products with sixteen-bit multipliers land shifted up by the unused multiplier bits.
    assign w_prod_short = w_prod[WB-DW +: NB];

    // One restoring division step: the next dividend bit comes out of the top of r_quo
    // while the quotient bit goes in at the bottom.
    always_comb begin
        n_trial = {r_rem, r_quo[P-1]};
        w_fits  = n_trial >= {1'b0, r_den};
        n_rem   = w_fits ? NB'(n_trial - {1'b0, r_den}) : n_trial[NB-1:0];
    end

    // Whole microseconds of the pulse sum.
    assign w_hi = r_acc[SB-1:tpsp_pkg::SUM_FRAC];

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tpsp_pkg::ST_IDLE: begin
                if (w_in_acc && (i_req_type == tpsp_pkg::REQ_TICK) && r_moving) begin
                    n_state = tpsp_pkg::ST_PREP;
                end
            end
            tpsp_pkg::ST_PREP: begin
                n_state = tpsp_pkg::ST_DEN;
            end
            tpsp_pkg::ST_DEN: begin
                if (w_mul_done) begin
                    n_state = tpsp_pkg::ST_NUM;
                end
            end
            tpsp_pkg::ST_NUM: begin
                if (w_mul_done) begin
                    n_state = tpsp_pkg::ST_SCALE;
                end
            end
            tpsp_pkg::ST_SCALE: begin
                if (w_mul_done) begin
                    n_state = tpsp_pkg::ST_DIV;
                end
            end
            tpsp_pkg::ST_DIV: begin
                if (r_dcnt == DCW'(1)) begin
                    n_state = tpsp_pkg::ST_POS;
                end
            end
            tpsp_pkg::ST_POS: begin
                n_state = tpsp_pkg::ST_SQUARE;
            end
            tpsp_pkg::ST_SQUARE: begin
                if (w_mul_done) begin
                    n_state = tpsp_pkg::ST_C2;
                end
            end
            tpsp_pkg::ST_C2: begin
                if (w_mul_done) begin
                    n_state = tpsp_pkg::ST_C1;
                end
            end
            tpsp_pkg::ST_C1: begin
                if (w_mul_done) begin
                    n_state = tpsp_pkg::ST_SAT;
                end
            end
            tpsp_pkg::ST_SAT: begin
                n_state = tpsp_pkg::ST_FINISH;
            end
            tpsp_pkg::ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = tpsp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tpsp_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: input ready, result hand-over and multiplier operands.
    // A multiplication starts in the first cycle of its state, flagged by r_kick.
    always_comb begin
        o_in_ready  = 1'b0;
        w_fin_load  = 1'b0;
        w_mul_start = 1'b0;
        w_mul_len   = '0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        unique case (r_state)
            tpsp_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            tpsp_pkg::ST_DEN: begin
                // Half the denominator: B * (N - B).
                w_mul_start = r_kick;
                w_mul_len   = LENW'(DW);
                w_mul_a     = AW'(w_rest);
                w_mul_b     = WB'(r_b);
            end
            tpsp_pkg::ST_NUM: begin
                w_mul_start = r_kick;
                w_mul_len   = LENW'(DW);
                case (r_phase)
                    tpsp_pkg::PH_RISE: begin
                        w_mul_a = AW'(r_n);
                        w_mul_b = WB'(r_n);
                    end
                    tpsp_pkg::PH_CRUISE: begin
                        w_mul_a = AW'({r_n, 1'b0} - (DW + 1)'(r_b));
                        w_mul_b = WB'(r_b);
                    end
                    default: begin
                        w_mul_a = AW'(r_rdist);
                        w_mul_b = WB'(r_rdist);
                    end
                endcase
            end
            tpsp_pkg::ST_SCALE: begin
                w_mul_start = r_kick;
                w_mul_len   = LENW'(P);
                w_mul_a     = AW'(r_num);
                w_mul_b     = WB'(r_mag);
            end
            tpsp_pkg::ST_SQUARE: begin
                w_mul_start = r_kick;
                w_mul_len   = LENW'(P);
                w_mul_a     = AW'(r_pos);
                w_mul_b     = WB'(r_pos);
            end
            tpsp_pkg::ST_C2: begin
                w_mul_start = r_kick;
                w_mul_len   = LENW'(WB);
                w_mul_a     = AW'(r_c2);
                w_mul_b     = r_sq;
            end
            tpsp_pkg::ST_C1: begin
                w_mul_start = r_kick;
                w_mul_len   = LENW'(P);
                w_mul_a     = AW'(r_c1);
                w_mul_b     = WB'(r_pos);
            end
            tpsp_pkg::ST_FINISH: begin
                w_fin_load = !r_out_valid || i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Control state, configuration registers and the kept move state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tpsp_pkg::ST_IDLE;
            r_kick      <= 1'b0;
            r_dur       <= DW'(tpsp_pkg::DUR_RESET);
            r_blend     <= BW'(tpsp_pkg::BLEND_RESET);
            r_c2        <= C2W'(tpsp_pkg::C2_RESET);
            r_c1        <= C1W'(tpsp_pkg::C1_RESET);
            r_c0        <= C0W'(tpsp_pkg::C0_RESET);
            r_start     <= '0;
            r_goal      <= '0;
            r_tick      <= '0;
            r_moving    <= 1'b0;
            r_out_valid <= 1'b0;
            r_dcnt      <= '0;
        end else begin
            r_state <= n_state;
            r_kick  <= (n_state != r_state);

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    tpsp_pkg::CFG_DURATION: r_dur   <= i_cfg_data[DW-1:0];
                    tpsp_pkg::CFG_BLEND:    r_blend <= i_cfg_data[BW-1:0];
                    tpsp_pkg::CFG_C2:       r_c2    <= i_cfg_data[C2W-1:0];
                    tpsp_pkg::CFG_C1:       r_c1    <= i_cfg_data[C1W-1:0];
                    tpsp_pkg::CFG_C0:       r_c0    <= i_cfg_data[C0W-1:0];
                    default: begin
                    end
                endcase
            end

            // A start item restarts the move from the kept start position.
            if (w_in_acc && (i_req_type == tpsp_pkg::REQ_START)) begin
                r_goal   <= i_target_pos;
                r_tick   <= '0;
                r_moving <= 1'b1;
            end

            if ((r_state == tpsp_pkg::ST_SCALE) && w_mul_done) begin
                r_dcnt <= DCW'(P);
            end else if (r_state == tpsp_pkg::ST_DIV) begin
                r_dcnt <= r_dcnt - DCW'(1);
            end

            if (w_fin_load) begin
                r_out_valid <= 1'b1;
                if (r_last) begin
                    r_start  <= r_pos;
                    r_tick   <= '0;
                    r_moving <= 1'b0;
                end else begin
                    r_tick <= r_tick + TICK_BITS'(1);
                end
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            tpsp_pkg::ST_PREP: begin
                r_nall <= w_nall;
                r_b    <= w_b;
                r_n    <= w_n;
                r_last <= w_last;
                r_down <= r_goal < r_start;
                r_mag  <= (r_goal < r_start) ? (r_start - r_goal) : (r_goal - r_start);
            end
            tpsp_pkg::ST_DEN: begin
                if (r_kick) begin
                    r_rdist <= r_nall - r_n;
                    if (r_n <= DW'(r_b)) begin
                        r_phase <= tpsp_pkg::PH_RISE;
                    end else if (r_n < w_rest) begin
                        r_phase <= tpsp_pkg::PH_CRUISE;
                    end else begin
                        r_phase <= tpsp_pkg::PH_FALL;
                    end
                end
                if (w_mul_done) begin
                    r_den <= {w_prod_short[NB-2:0], 1'b0};
                end
            end
            tpsp_pkg::ST_NUM: begin
                // In the final blend the numerator counts down from the denominator.
                if (w_mul_done) begin
                    r_num <= (r_phase == tpsp_pkg::PH_FALL) ? (r_den - w_prod_short)
                                                           : w_prod_short;
                end
            end
            tpsp_pkg::ST_SCALE: begin
                // The offset never exceeds the distance, so the upper part of the dividend
                // is already below the denominator.
                if (w_mul_done) begin
                    r_rem <= w_prod[WB +: NB];
                    r_quo <= w_prod[P +: P];
                end
            end
            tpsp_pkg::ST_DIV: begin
                r_rem <= n_rem;
                r_quo <= {r_quo[P-2:0], w_fits};
            end
            tpsp_pkg::ST_POS: begin
                r_pos <= r_down ? (r_start - r_quo) : (r_start + r_quo);
            end
            tpsp_pkg::ST_SQUARE: begin
                if (w_mul_done) begin
                    r_sq <= w_prod[P +: WB];
                end
            end
            tpsp_pkg::ST_C2: begin
                if (w_mul_done) begin
                    r_acc <= SB'(w_prod) + (SB'(r_c0) << tpsp_pkg::C0_ALIGN);
                end
            end
            tpsp_pkg::ST_C1: begin
                if (w_mul_done) begin
                    r_acc <= r_acc + (SB'(w_prod[P +: C1W + P]) << tpsp_pkg::C1_ALIGN);
                end
            end
            tpsp_pkg::ST_SAT: begin
                if (w_hi < HIW'(tpsp_pkg::PULSE_MIN)) begin
                    r_pulse <= PW'(tpsp_pkg::PULSE_MIN);
                end else if (w_hi > HIW'(tpsp_pkg::PULSE_MAX)) begin
                    r_pulse <= PW'(tpsp_pkg::PULSE_MAX);
                end else begin
                    r_pulse <= w_hi[PW-1:0];
                end
            end
            default: begin
            end
        endcase

        if (w_fin_load) begin
            r_out_pulse <= r_pulse;
            r_out_pos   <= r_pos;
            r_out_last  <= r_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pulse_us     = r_out_pulse;
    assign o_profile_pos  = r_out_pos;
    assign o_last_of_move = r_out_last;

endmodule

`default_nettype wire

>>> test/tb.sv
`default_nettype none

// Self-checking bench for the trapezoidal servo move generator.
//
// Requests are queued by the stimulus process and fed to the block by a clocked
// driver. The driver runs a behavioural copy of the profile generator at every
// accepted item, so the expected profile points are known in the order they must
// leave the block. A clocked monitor takes the points off the output channel,
// stalling at random, and checks each one against the oldest expected point.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tpsp_pkg::*;

    localparam int POS_W         = POS_BITS_DEFAULT;
    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 4;
    // The settle pause before a register write leaves room for two ticks of a running move
    // to be worked through inside the block.
    localparam int SETTLE_CYCLES = 300;
    localparam int LONG_HOLD     = 600;
    localparam int QUIET_LIMIT   = 5000;
    localparam int RANDOM_ITEMS  = 450;
    localparam int HOLD_PHASE    = 3;
    // An index with no register behind it; the block must ignore the write.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 3'd7;

    typedef struct packed {
        t_req             kind;
        logic [POS_W-1:0] target;
    } servo_req_t;

    typedef struct packed {
        logic [PULSE_BITS-1:0] pulse;
        logic [POS_W-1:0]      pos;
        logic                  last;
    } servo_point_t;

    // Every input is known from time zero.
    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     in_valid    = 1'b0;
    t_req                     req_kind    = REQ_START;
    logic [POS_W-1:0]         target_pos  = '0;
    logic                     out_ready   = 1'b0;
    logic                     cfg_valid   = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index   = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data    = '0;

    logic                     in_ready;
    logic                     out_valid;
    logic [PULSE_BITS-1:0]    pulse_us;
    logic [POS_W-1:0]         profile_pos;
    logic                     last_of_move;
    logic                     cfg_ready;

    trapezoidal_profile_servo_pulse_core dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_req_type     (req_kind),
        .i_target_pos   (target_pos),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_pulse_us     (pulse_us),
        .o_profile_pos  (profile_pos),
        .o_last_of_move (last_of_move),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // Items waiting to be offered, and profile points waiting to come out.
    servo_req_t   queued_requests[$];
    servo_point_t pending_points[$];

    int errors        = 0;
    // Idling controls, changed by the stimulus process on the falling edge only.
    bit in_gap_mode   = 1'b0;
    bit out_gap_mode  = 1'b0;
    int hold_requests = 0;

    // Behavioural copy of the registers and of the move state.
    logic [DUR_BITS-1:0]   dur_q   = DUR_RESET;
    logic [BLEND_BITS-1:0] blend_q = BLEND_RESET;
    logic [C2_BITS-1:0]    c2_q    = C2_RESET;
    logic [C1_BITS-1:0]    c1_q    = C1_RESET;
    logic [C0_BITS-1:0]    c0_q    = C0_RESET;
    logic [POS_W-1:0]      start_q = '0;
    logic [POS_W-1:0]      goal_q  = '0;
    logic [15:0]           tick_q  = '0;
    bit                    moving_q = 1'b0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic void store_register(input logic [CFG_IDX_BITS-1:0] idx,
                                           input logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            CFG_DURATION: dur_q   = data[DUR_BITS-1:0];
            CFG_BLEND:    blend_q = data[BLEND_BITS-1:0];
            CFG_C2:       c2_q    = data[C2_BITS-1:0];
            CFG_C1:       c1_q    = data[C1_BITS-1:0];
            CFG_C0:       c0_q    = data[C0_BITS-1:0];
            default: ;
        endcase
    endfunction

    // Quadratic pulse map. The integer and fractional parts of each term are kept apart,
    // with the fractions aligned to 32 bits, so the floor of the exact sum comes out.
    function automatic logic [PULSE_BITS-1:0] servo_pulse_of(input logic [POS_W-1:0] p);
        bit [63:0] pw, sq, hi2, lo2, lin, hi1, lo1, hi0, lo0, total;
        pw  = 64'(p);
        sq  = pw * pw;
        hi2 = 64'(c2_q) * (sq >> 32);
        lo2 = 64'(c2_q) * (sq & 64'hFFFF_FFFF);
        lin = 64'(c1_q) * pw;
        hi1 = lin >> 24;
        lo1 = (lin & 64'hFF_FFFF) << 8;
        hi0 = 64'(c0_q) >> 16;
        lo0 = (64'(c0_q) & 64'hFFFF) << 16;
        hi2 = hi2 + (lo2 >> 32);
        lo2 = lo2 & 64'hFFFF_FFFF;
        total = hi2 + hi1 + hi0 + ((lo2 + lo1 + lo0) >> 32);
        if (total < PULSE_MIN) total = PULSE_MIN;
        if (total > PULSE_MAX) total = PULSE_MAX;
        return total[PULSE_BITS-1:0];
    endfunction

    // Advances the move by one accepted item. Returns 1 when the item yields a point.
    function automatic bit advance_profile(input t_req kind, input logic [POS_W-1:0] target,
                                           output servo_point_t pt);
        bit [63:0] n_all, b, n, den, num, mag, off, pos, r;
        bit        last;
        t_phase    ph;
        pt = '0;
        if (kind == REQ_START) begin
            // A start always rewinds to the first point; the start position is kept.
            goal_q   = target;
            tick_q   = '0;
            moving_q = 1'b1;
            return 1'b0;
        end
        if (!moving_q) return 1'b0;

        // A duration below two counts as two, and the blend is held within 1..N/2.
        n_all = 64'(dur_q);
        if (n_all < DUR_MIN) n_all = DUR_MIN;
        b = 64'(blend_q);
        if (b > n_all / 2) b = n_all / 2;
        if (b < 1) b = 1;

        // An index that has run past a lowered duration is taken as the final point.
        n    = 64'(tick_q);
        last = (n >= n_all);
        if (last) n = n_all;

        den = 2 * b * (n_all - b);
        if (n <= b) ph = PH_RISE;
        else if (n < n_all - b) ph = PH_CRUISE;
        else ph = PH_FALL;
        case (ph)
            PH_RISE:   num = n * n;
            PH_CRUISE: num = b * (2 * n - b);
            default: begin
                r   = n_all - n;
                num = den - r * r;
            end
        endcase

        // The offset is truncated towards zero in both directions of travel.
        if (goal_q >= start_q) begin
            mag = 64'(goal_q - start_q);
            off = (mag * num) / den;
            pos = 64'(start_q) + off;
        end else begin
            mag = 64'(start_q - goal_q);
            off = (mag * num) / den;
            pos = 64'(start_q) - off;
        end

        pt.pos   = pos[POS_W-1:0];
        pt.pulse = servo_pulse_of(pos[POS_W-1:0]);
        pt.last  = last;
        if (last) begin
            start_q  = pos[POS_W-1:0];
            tick_q   = '0;
            moving_q = 1'b0;
        end else begin
            tick_q = tick_q + 16'd1;
        end
        return 1'b1;
    endfunction

    // Driver. The payload is held until the item is taken; after an item is taken a gap may
    // follow before the next one is offered.
    int in_gap = 0;

    always @(posedge clk) begin : drive_requests
        servo_point_t pt;
        servo_req_t   nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                if (advance_profile(req_kind, target_pos, pt)) pending_points.push_back(pt);
            end
            if (in_valid && !in_ready) begin
                // Still waiting for the block: everything stays as it is.
            end else if (in_gap > 0) begin
                in_valid <= 1'b0;
                in_gap   <= in_gap - 1;
            end else if (queued_requests.size() > 0) begin
                nxt = queued_requests.pop_front();
                in_valid   <= 1'b1;
                req_kind   <= nxt.kind;
                target_pos <= nxt.target;
                if (in_gap_mode) in_gap <= pick_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor. Besides the random stalls, a long hold-off can be requested; while it runs the
    // sender keeps offering items, so the output register fills and the input stalls.
    int out_stall   = 0;
    int hold_left   = 0;
    int holds_taken = 0;

    always @(posedge clk) begin : collect_points
        servo_point_t want;
        bit           took;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            took = out_valid && out_ready;
            if (took) begin
                if (pending_points.size() == 0) begin
                    report_mismatch($sformatf("point at position %0d came with none expected",
                                              profile_pos));
                end else begin
                    want = pending_points.pop_front();
                    if (pulse_us !== want.pulse)
                        report_mismatch($sformatf("pulse_us got %0d, expected %0d",
                                                  pulse_us, want.pulse));
                    if (profile_pos !== want.pos)
                        report_mismatch($sformatf("profile_pos got %0d, expected %0d",
                                                  profile_pos, want.pos));
                    if (last_of_move !== want.last)
                        report_mismatch($sformatf("last_of_move got %0b, expected %0b",
                                                  last_of_move, want.last));
                end
            end
            if (holds_taken < hold_requests && hold_left == 0) begin
                out_ready   <= 1'b0;
                hold_left   <= LONG_HOLD;
                holds_taken <= holds_taken + 1;
            end else if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (out_stall > 0) begin
                out_ready <= 1'b0;
                out_stall <= out_stall - 1;
            end else begin
                out_ready <= 1'b1;
                if (out_gap_mode && (took || $urandom_range(0, 7) == 0)) out_stall <= pick_gap();
            end
        end
    end

    // Watchdog: a long stretch in which no channel moves anything means the block has hung.
    int quiet = 0;

    always @(posedge clk) begin : watchdog
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
                quiet <= 0;
            end else if (quiet >= QUIET_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end else begin
                quiet <= quiet + 1;
            end
        end
    end

    task automatic push_req(input t_req kind, input logic [POS_W-1:0] target);
        servo_req_t req;
        req.kind   = kind;
        req.target = target;
        queued_requests.push_back(req);
    endtask

    // Returns once every item has been taken and every point has come out, plus a pause in
    // which a start item, which gives no point, can still be finishing inside the block.
    task automatic wait_quiet();
        do @(posedge clk);
        while (queued_requests.size() != 0 || in_valid || pending_points.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk);
        while (!cfg_ready);
        store_register(idx, data);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int               planned;
        int               phase;
        int               moves;
        int               ticks;
        int               eff_n;
        logic [15:0]      dur_val;
        logic [15:0]      blend_val;
        logic [POS_W-1:0] goal;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, with the reset register values first. A tick with no move running is
        // ignored; then the first points of a long move from zero to full scale.
        @(negedge clk);
        push_req(REQ_TICK, 16'hABCD);
        push_req(REQ_START, 16'hFFFF);
        repeat (3) push_req(REQ_TICK, '0);
        wait_quiet();

        // Lowering the duration to the tick index makes the next tick the final point.
        write_reg(CFG_DURATION, 28'd3);
        @(negedge clk);
        push_req(REQ_TICK, '0);
        push_req(REQ_TICK, '0);
        wait_quiet();

        // Shortest move, zero blend, pulse map coefficients at their top values (the data is
        // wider than the registers, so the masking is exercised too), and a write to an index
        // that has no register.
        write_reg(CFG_DURATION, 28'd0);
        write_reg(CFG_BLEND, 28'd0);
        write_reg(CFG_C2, 28'hFFF_FFFF);
        write_reg(CFG_C1, 28'hFFF_FFFF);
        write_reg(CFG_C0, 28'hFFF_FFFF);
        write_reg(CFG_SPARE, 28'h5A5_A5A5);
        @(negedge clk);
        // A downward move, two starts in a row, and a restart in the middle of a move.
        push_req(REQ_START, 16'h0000);
        repeat (3) push_req(REQ_TICK, '0);
        push_req(REQ_START, 16'h1234);
        push_req(REQ_START, 16'h0001);
        push_req(REQ_TICK, '0);
        push_req(REQ_START, 16'hFFFF);
        repeat (3) push_req(REQ_TICK, '0);
        wait_quiet();

        // Zero coefficients drive the pulse to its floor; longest move and longest blend.
        write_reg(CFG_C2, 28'd0);
        write_reg(CFG_C1, 28'd0);
        write_reg(CFG_C0, 28'd0);
        write_reg(CFG_DURATION, 28'd65535);
        write_reg(CFG_BLEND, 28'd32767);
        @(negedge clk);
        push_req(REQ_START, 16'h8000);
        repeat (4) push_req(REQ_TICK, '0);
        wait_quiet();

        // Cut the move short; the oversized blend is now clamped to half the duration.
        write_reg(CFG_DURATION, 28'd5);
        @(negedge clk);
        push_req(REQ_TICK, '0);
        push_req(REQ_TICK, '0);
        wait_quiet();

        // Random part. Each phase picks new register values, then runs a few moves, most of
        // them complete, some cut short by a restart, and a little noise.
        planned = 0;
        phase   = 0;
        while (planned < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       dur_val = $urandom_range(0, 1);
                1:       dur_val = $urandom_range(15, 65535);
                default: dur_val = $urandom_range(2, 14);
            endcase
            case ($urandom_range(0, 9))
                0:       blend_val = 16'd0;
                1:       blend_val = 16'h7FFF;
                2:       blend_val = $urandom_range(0, 32767);
                default: blend_val = $urandom_range(1, 8);
            endcase
            if (phase == HOLD_PHASE) dur_val = 16'd8;
            write_reg(CFG_DURATION, {$urandom_range(0, 4095), dur_val});
            write_reg(CFG_BLEND, {$urandom_range(0, 8191), blend_val[14:0]});
            case ($urandom_range(0, 5))
                0: begin
                    // Raw data over the full bus width.
                    write_reg(CFG_C2, $urandom_range(0, 28'hFFF_FFFF));
                    write_reg(CFG_C1, $urandom_range(0, 28'hFFF_FFFF));
                    write_reg(CFG_C0, $urandom_range(0, 28'hFFF_FFFF));
                end
                1: begin
                    write_reg(CFG_C2, 28'hFFF_FFFF);
                    write_reg(CFG_C1, 28'hFFF_FFFF);
                    write_reg(CFG_C0, 28'hFFF_FFFF);
                end
                2: begin
                    write_reg(CFG_C2, 28'd0);
                    write_reg(CFG_C1, 28'd0);
                    write_reg(CFG_C0, 28'd0);
                end
                default: begin
                    // Close to a real servo, so that many pulses fall inside the limits.
                    write_reg(CFG_C2, $urandom_range(0, 700));
                    write_reg(CFG_C1, $urandom_range(200000, 700000));
                    write_reg(CFG_C0, $urandom_range(20000000, 40000000));
                end
            endcase
            if ($urandom_range(0, 7) == 0)
                write_reg($urandom_range(5, 7), $urandom_range(0, 28'hFFF_FFFF));

            @(negedge clk);
            in_gap_mode  = ($urandom_range(0, 3) != 0);
            out_gap_mode = ($urandom_range(0, 3) != 0);
            eff_n = (dur_val < DUR_MIN) ? DUR_MIN : int'(dur_val);

            if (phase == HOLD_PHASE) begin
                // The sender pushes without gaps while the receiver holds off.
                in_gap_mode = 1'b0;
                hold_requests++;
                push_req(REQ_START, $urandom_range(0, 65535));
                repeat (eff_n + 1) push_req(REQ_TICK, $urandom_range(0, 65535));
                planned += eff_n + 2;
            end

            // Ticks that carry on a move left running by the previous phase under the new
            // registers.
            if ($urandom_range(0, 1) == 1) begin
                ticks = $urandom_range(1, 2);
                repeat (ticks) push_req(REQ_TICK, $urandom_range(0, 65535));
                planned += ticks;
            end

            moves = $urandom_range(1, 3);
            repeat (moves) begin
                case ($urandom_range(0, 7))
                    0:       goal = '0;
                    1:       goal = '1;
                    default: goal = $urandom_range(0, 65535);
                endcase
                push_req(REQ_START, goal);
                if (eff_n > 20) begin
                    ticks = $urandom_range(1, 5);
                end else begin
                    case ($urandom_range(0, 9))
                        7, 8:    ticks = $urandom_range(0, eff_n);
                        9:       ticks = 0;
                        default: ticks = eff_n + 1;
                    endcase
                end
                repeat (ticks) push_req(REQ_TICK, $urandom_range(0, 65535));
                planned += ticks + 1;
                // Noise: items of either kind with random payload.
                if ($urandom_range(0, 5) == 0) begin
                    repeat ($urandom_range(1, 4))
                        push_req(t_req'($urandom_range(0, 1)), $urandom_range(0, 65535));
                end
            end
            wait_quiet();
            phase++;
        end

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
design/tpsp_pkg.sv
design/tpsp_shift_mul.sv
design/trapezoidal_profile_servo_pulse_core.sv
test/tb.sv
